// ===== hw/rtl/ccdh_pkg.sv =====
// ----------------------------------------------------------------------------
// ccdh_pkg
// Shared types and constants for the debounced hysteresis cooler controller.
// ----------------------------------------------------------------------------
`default_nettype none

package ccdh_pkg;

    localparam int VAL_W   = 10;   // heat index / humidity, tenths
    localparam int DEB_W   = 4;
    localparam int CNT_W   = 5;
    localparam int MS_W    = 32;   // timestamp and interval fields
    localparam int CFG_IDX_W = 3;

    localparam logic [CNT_W-1:0] COUNT_MAX = 5'd31;

    // register indexes on the config port
    localparam logic [CFG_IDX_W-1:0] CFG_ON_INDEX    = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_OFF_INDEX   = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_HUMID_ON    = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_HUMID_OFF   = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_DEBOUNCE    = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_REPEAT_INTV = 3'd5;

    // reset values of the config registers
    localparam logic [VAL_W-1:0] RST_ON_INDEX    = 10'd272;
    localparam logic [VAL_W-1:0] RST_OFF_INDEX   = 10'd268;
    localparam logic [VAL_W-1:0] RST_HUMID_ON    = 10'd330;
    localparam logic [VAL_W-1:0] RST_HUMID_OFF   = 10'd300;
    localparam logic [DEB_W-1:0] RST_DEBOUNCE    = 4'd6;
    localparam logic [MS_W-1:0]  RST_REPEAT_INTV = 32'd600000;

    typedef enum logic [3:0] {
        MODE_OFF      = 4'd0,
        MODE_CONF_ON  = 4'd1,
        MODE_ON       = 4'd2,
        MODE_CONF_OFF = 4'd3,
        MODE_DISABLING = 4'd4,
        MODE_CONF_DIS = 4'd5,
        MODE_DISABLED = 4'd6,
        MODE_CONF_EN  = 4'd7,
        MODE_FAULT    = 4'd8
    } mode_t;

    typedef struct packed {
        logic [VAL_W-1:0] on_index_limit;
        logic [VAL_W-1:0] off_index_limit;
        logic [VAL_W-1:0] humid_on_floor;
        logic [VAL_W-1:0] humid_off_floor;
        logic [DEB_W-1:0] debounce_limit;
        logic [MS_W-1:0]  repeat_interval_ms;
    } cfg_t;

    typedef struct packed {
        logic [MS_W-1:0]  now_ms;
        logic             enable_switch;
        logic             sensor_error;
        logic [VAL_W-1:0] humidity;
        logic [VAL_W-1:0] heat_index;
    } item_t;

    typedef struct packed {
        logic  fault_cmd;
        logic  repeat_cmd;
        logic  power_toggle_cmd;
        logic  cool_stop_cmd;
        logic  cool_start_cmd;
        mode_t mode_code;
    } result_t;

endpackage : ccdh_pkg

`default_nettype wire

// ===== hw/rtl/ccdh_cfg_regs.sv =====
// ----------------------------------------------------------------------------
// ccdh_cfg_regs
// Configuration register file: thresholds, debounce limit, repeat interval.
// ----------------------------------------------------------------------------
`default_nettype none

module ccdh_cfg_regs (
    input  wire logic                            aclk,
    input  wire logic                            aresetn,
    input  wire logic                            cfg_wr_en,
    input  wire logic [ccdh_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [ccdh_pkg::MS_W-1:0]       cfg_wdata,
    output ccdh_pkg::cfg_t                       cfg
);

    ccdh_pkg::cfg_t cfg_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.on_index_limit     <= ccdh_pkg::RST_ON_INDEX;
            cfg_reg.off_index_limit    <= ccdh_pkg::RST_OFF_INDEX;
            cfg_reg.humid_on_floor     <= ccdh_pkg::RST_HUMID_ON;
            cfg_reg.humid_off_floor    <= ccdh_pkg::RST_HUMID_OFF;
            cfg_reg.debounce_limit     <= ccdh_pkg::RST_DEBOUNCE;
            cfg_reg.repeat_interval_ms <= ccdh_pkg::RST_REPEAT_INTV;
        end else if (cfg_wr_en) begin
            unique case (cfg_index)
                ccdh_pkg::CFG_ON_INDEX:
                    cfg_reg.on_index_limit <= cfg_wdata[ccdh_pkg::VAL_W-1:0];
                ccdh_pkg::CFG_OFF_INDEX:
                    cfg_reg.off_index_limit <= cfg_wdata[ccdh_pkg::VAL_W-1:0];
                ccdh_pkg::CFG_HUMID_ON:
                    cfg_reg.humid_on_floor <= cfg_wdata[ccdh_pkg::VAL_W-1:0];
                ccdh_pkg::CFG_HUMID_OFF:
                    cfg_reg.humid_off_floor <= cfg_wdata[ccdh_pkg::VAL_W-1:0];
                ccdh_pkg::CFG_DEBOUNCE:
                    cfg_reg.debounce_limit <= cfg_wdata[ccdh_pkg::DEB_W-1:0];
                ccdh_pkg::CFG_REPEAT_INTV:
                    cfg_reg.repeat_interval_ms <= cfg_wdata;
                default: ;  // unmapped index, dropped
            endcase
        end
    end

    assign cfg = cfg_reg;

endmodule : ccdh_cfg_regs

`default_nettype wire

// ===== hw/rtl/ccdh_ctrl.sv =====
// ----------------------------------------------------------------------------
// ccdh_ctrl
// Nine-state cooler controller: state, debounce counter and repeat timer.
// ----------------------------------------------------------------------------
`default_nettype none

module ccdh_ctrl #(
    parameter int TIME_WIDTH = 32
) (
    input  wire logic            aclk,
    input  wire logic            aresetn,
    input  wire logic            step_en,
    input  wire ccdh_pkg::item_t item,
    input  wire ccdh_pkg::cfg_t  cfg,
    output ccdh_pkg::result_t    result
);

    localparam int WIDE_W = 64;

    ccdh_pkg::mode_t mode_reg, mode_next, mode_eff;
    logic [ccdh_pkg::CNT_W-1:0] count_reg, count_next, count_inc;
    logic [TIME_WIDTH-1:0] last_reg, last_next, now_t, elapsed;
    logic [WIDE_W-1:0] now_wide, elapsed_wide, intv_wide;
    logic on_cond, off_cond, repeat_due, count_done, err, en;

    assign err = item.sensor_error;
    assign en  = item.enable_switch;

    assign on_cond = (item.heat_index > cfg.on_index_limit) &&
                     (item.humidity > cfg.humid_on_floor);
    assign off_cond = (item.heat_index < cfg.off_index_limit) ||
                      (item.humidity < cfg.humid_off_floor);

    // wrapping time difference at TIME_WIDTH bits
    assign now_wide     = {{(WIDE_W-ccdh_pkg::MS_W){1'b0}}, item.now_ms};
    assign now_t        = now_wide[TIME_WIDTH-1:0];
    assign elapsed      = now_t - last_reg;
    assign elapsed_wide = WIDE_W'(elapsed);
    assign intv_wide    = {{(WIDE_W-ccdh_pkg::MS_W){1'b0}}, cfg.repeat_interval_ms};
    assign repeat_due   = elapsed_wide >= intv_wide;

    assign count_inc  = (count_reg == ccdh_pkg::COUNT_MAX) ? count_reg
                                                           : count_reg + 1'b1;
    assign count_done = count_inc > {1'b0, cfg.debounce_limit};

    // a sensor error overrides every mode but disabling and disabled
    always_comb begin
        mode_eff = mode_reg;
        if (err && mode_reg != ccdh_pkg::MODE_DISABLED &&
            mode_reg != ccdh_pkg::MODE_DISABLING) begin
            mode_eff = ccdh_pkg::MODE_FAULT;
        end
    end

    // next state
    always_comb begin
        mode_next  = mode_eff;
        count_next = count_reg;
        last_next  = last_reg;
        unique case (mode_eff)
            ccdh_pkg::MODE_OFF, ccdh_pkg::MODE_ON: begin
                if (!en) begin
                    mode_next = ccdh_pkg::MODE_DISABLING;
                end else if ((mode_eff == ccdh_pkg::MODE_OFF) ? on_cond : off_cond) begin
                    mode_next  = (mode_eff == ccdh_pkg::MODE_OFF) ? ccdh_pkg::MODE_CONF_ON
                                                                  : ccdh_pkg::MODE_CONF_OFF;
                    count_next = '0;
                end else if (repeat_due) begin
                    last_next = now_t;
                end
            end
            ccdh_pkg::MODE_CONF_ON, ccdh_pkg::MODE_CONF_OFF: begin
                if (!en) begin
                    mode_next = ccdh_pkg::MODE_DISABLING;
                end else if ((mode_eff == ccdh_pkg::MODE_CONF_ON) ? on_cond : off_cond) begin
                    count_next = count_inc;
                    if (count_done) begin
                        mode_next = (mode_eff == ccdh_pkg::MODE_CONF_ON) ? ccdh_pkg::MODE_ON
                                                                         : ccdh_pkg::MODE_OFF;
                        last_next = now_t;
                    end
                end else begin
                    count_next = '0;
                    mode_next  = (mode_eff == ccdh_pkg::MODE_CONF_ON) ? ccdh_pkg::MODE_OFF
                                                                      : ccdh_pkg::MODE_ON;
                end
            end
            ccdh_pkg::MODE_DISABLING: begin
                count_next = '0;
                mode_next  = ccdh_pkg::MODE_CONF_DIS;
            end
            ccdh_pkg::MODE_CONF_DIS: begin
                if (!en) begin
                    count_next = count_inc;
                    if (count_done) begin
                        mode_next = ccdh_pkg::MODE_DISABLED;
                    end
                end else begin
                    count_next = '0;
                    mode_next  = ccdh_pkg::MODE_OFF;
                end
            end
            ccdh_pkg::MODE_DISABLED: begin
                if (en) begin
                    mode_next  = ccdh_pkg::MODE_CONF_EN;
                    count_next = '0;
                end
            end
            ccdh_pkg::MODE_CONF_EN: begin
                if (en) begin
                    count_next = count_inc;
                    if (count_done) begin
                        mode_next = ccdh_pkg::MODE_OFF;
                    end
                end else begin
                    count_next = '0;
                    mode_next  = ccdh_pkg::MODE_DISABLED;
                end
            end
            ccdh_pkg::MODE_FAULT: begin
                if (!err) begin
                    mode_next = ccdh_pkg::MODE_OFF;
                end
            end
            default: begin
                mode_next = ccdh_pkg::MODE_OFF;
            end
        endcase
    end

    // command outputs
    always_comb begin
        result.mode_code        = mode_next;
        result.cool_start_cmd   = 1'b0;
        result.cool_stop_cmd    = 1'b0;
        result.power_toggle_cmd = 1'b0;
        result.repeat_cmd       = 1'b0;
        result.fault_cmd        = 1'b0;
        unique case (mode_eff)
            ccdh_pkg::MODE_OFF: begin
                result.repeat_cmd = en && !on_cond && repeat_due;
            end
            ccdh_pkg::MODE_ON: begin
                result.repeat_cmd = en && !off_cond && repeat_due;
            end
            ccdh_pkg::MODE_CONF_ON: begin
                result.cool_start_cmd = en && on_cond && count_done;
            end
            ccdh_pkg::MODE_CONF_OFF: begin
                result.cool_stop_cmd = en && off_cond && count_done;
            end
            ccdh_pkg::MODE_CONF_DIS: begin
                result.cool_stop_cmd    = !en && count_done;
                result.power_toggle_cmd = !en && count_done;
            end
            ccdh_pkg::MODE_CONF_EN: begin
                result.power_toggle_cmd = en && count_done;
            end
            ccdh_pkg::MODE_FAULT: begin
                result.fault_cmd = 1'b1;
            end
            default: ;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mode_reg  <= ccdh_pkg::MODE_OFF;
            count_reg <= '0;
            last_reg  <= '0;
        end else if (step_en) begin
            mode_reg  <= mode_next;
            count_reg <= count_next;
            last_reg  <= last_next;
        end
    end

endmodule : ccdh_ctrl

`default_nettype wire

// ===== hw/rtl/cooler_debounced_hysteresis_fsm.sv =====
// ----------------------------------------------------------------------------
// cooler_debounced_hysteresis_fsm
// Debounced hysteresis cooler controller, one result per evaluation sample.
// ----------------------------------------------------------------------------
// Usage:
//   Samples enter on the s_ stream; each sample gives exactly one result on
//   the m_ stream carrying the new mode and the key commands to issue.
//   Thresholds, debounce limit and repeat interval are set through the plain
//   write port (cfg_wr_en/cfg_index/cfg_wdata) while no sample is in flight.
//   A sample passes two register stages: the input register, then the result
//   register. One sample per cycle while m_ does not stall; the controller
//   state updates as a sample moves from the input to the result register.
//   When the receiver stalls, the result register holds and the input
//   register still takes one more sample; s_tready drops only once both are
//   full.
//   Reset (aresetn low, synchronous) empties both stages, puts the controller
//   in the off state with counter and repeat timestamp at zero, and restores
//   the default configuration.
// ----------------------------------------------------------------------------
`default_nettype none

module cooler_debounced_hysteresis_fsm #(
    parameter int TIME_WIDTH = 32
) (
    input  wire logic                           aclk,
    input  wire logic                           aresetn,
    // heat_index[9:0], humidity[19:10], enable_switch[20], now_ms[52:21]
    input  wire logic [55:0]                    s_tdata,
    // sensor_error[0]
    input  wire logic                           s_tuser,
    input  wire logic                           s_tvalid,
    output logic                                s_tready,
    // mode_code[3:0], cool_start_cmd[4], cool_stop_cmd[5],
    // power_toggle_cmd[6], repeat_cmd[7], fault_cmd[8]
    output logic [15:0]                         m_tdata,
    output logic                                m_tvalid,
    input  wire logic                           m_tready,
    input  wire logic                           cfg_wr_en,
    input  wire logic [ccdh_pkg::CFG_IDX_W-1:0] cfg_index,
    input  wire logic [ccdh_pkg::MS_W-1:0]      cfg_wdata
);

    ccdh_pkg::cfg_t    cfg;
    ccdh_pkg::item_t   in_item_reg;
    ccdh_pkg::result_t step_result, out_result_reg;
    logic in_valid_reg, out_valid_reg, step_en, in_xfer;

    ccdh_cfg_regs u_cfg (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .cfg       (cfg)
    );

    // step fires when the input stage holds a sample and the result slot frees
    assign step_en  = in_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready = !in_valid_reg || step_en;
    assign in_xfer  = s_tvalid && s_tready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (in_xfer) begin
            in_valid_reg <= 1'b1;
        end else if (step_en) begin
            in_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (in_xfer) begin
            in_item_reg.heat_index    <= s_tdata[9:0];
            in_item_reg.humidity      <= s_tdata[19:10];
            in_item_reg.enable_switch <= s_tdata[20];
            in_item_reg.now_ms        <= s_tdata[52:21];
            in_item_reg.sensor_error  <= s_tuser;
        end
    end

    ccdh_ctrl #(
        .TIME_WIDTH (TIME_WIDTH)
    ) u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .step_en (step_en),
        .item    (in_item_reg),
        .cfg     (cfg),
        .result  (step_result)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (step_en) begin
            out_valid_reg <= 1'b1;
        end else if (m_tready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (step_en) begin
            out_result_reg <= step_result;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {7'd0,
                       out_result_reg.fault_cmd,
                       out_result_reg.repeat_cmd,
                       out_result_reg.power_toggle_cmd,
                       out_result_reg.cool_stop_cmd,
                       out_result_reg.cool_start_cmd,
                       out_result_reg.mode_code};

endmodule : cooler_debounced_hysteresis_fsm

`default_nettype wire

// ===== bench/tb_cooler_debounced_hysteresis_fsm.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_cooler_debounced_hysteresis_fsm
// Self-checking bench for the debounced hysteresis cooler controller. A queue
// of samples feeds a clocked stream driver; a predictor tracks mode, confirm
// count and repeat timestamp and queues one expected result per transfer; a
// clocked monitor checks every result field. The run goes through reset,
// extreme and random threshold settings, with random stalls on both sides.
// ----------------------------------------------------------------------------
module tb_cooler_debounced_hysteresis_fsm;

    localparam logic [ccdh_pkg::CFG_IDX_W-1:0] CFG_SPARE_6 = 3'd6;
    localparam logic [ccdh_pkg::CFG_IDX_W-1:0] CFG_SPARE_7 = 3'd7;
    localparam int VAL_MAX = 1023;

    typedef enum int {RUN_HOT, RUN_COLD, RUN_MID, RUN_NOISE} run_kind_t;

    logic                           aclk      = 1'b0;
    logic                           aresetn   = 1'b0;
    logic [55:0]                    s_tdata   = '0;
    logic                           s_tuser   = 1'b0;
    logic                           s_tvalid  = 1'b0;
    logic                           s_tready;
    logic [15:0]                    m_tdata;
    logic                           m_tvalid;
    logic                           m_tready  = 1'b0;
    logic                           cfg_wr_en = 1'b0;
    logic [ccdh_pkg::CFG_IDX_W-1:0] cfg_index = '0;
    logic [ccdh_pkg::MS_W-1:0]      cfg_wdata = '0;

    cooler_debounced_hysteresis_fsm i_dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .m_tdata   (m_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata)
    );

    always #2 aclk = ~aclk;

    // controller copy kept by the bench
    ccdh_pkg::cfg_t               model_cfg;
    ccdh_pkg::mode_t              ctl_mode;
    logic [ccdh_pkg::CNT_W-1:0]   ctl_count;
    logic [ccdh_pkg::MS_W-1:0]    last_action;

    ccdh_pkg::item_t   pending_samples[$];
    ccdh_pkg::result_t expected_results[$];
    ccdh_pkg::item_t   offered;
    logic [ccdh_pkg::MS_W-1:0] stamp_ms = '0;

    int src_gap       = 0;
    int sink_gap      = 0;
    int hold_left     = 0;
    int results_seen  = 0;
    int fail_count    = 0;
    int src_idle_pct  = 0;
    int sink_idle_pct = 0;

    function automatic logic repeat_due(input logic [ccdh_pkg::MS_W-1:0] now);
        logic [ccdh_pkg::MS_W-1:0] elapsed;
        elapsed = now - last_action;
        if (elapsed >= model_cfg.repeat_interval_ms) begin
            last_action = now;
            return 1'b1;
        end
        return 1'b0;
    endfunction

    function automatic void bump_count();
        if (ctl_count != ccdh_pkg::COUNT_MAX)
            ctl_count = ctl_count + 1'b1;
    endfunction

    function automatic ccdh_pkg::result_t cooler_step(input ccdh_pkg::item_t it);
        ccdh_pkg::result_t r;
        logic              on_c, off_c, en;
        r     = '0;
        en    = it.enable_switch;
        on_c  = it.heat_index > model_cfg.on_index_limit &&
                it.humidity > model_cfg.humid_on_floor;
        off_c = it.heat_index < model_cfg.off_index_limit ||
                it.humidity < model_cfg.humid_off_floor;

        // error overrides every mode except disabling and disabled
        if (it.sensor_error && ctl_mode != ccdh_pkg::MODE_DISABLED &&
            ctl_mode != ccdh_pkg::MODE_DISABLING)
            ctl_mode = ccdh_pkg::MODE_FAULT;

        case (ctl_mode)
            ccdh_pkg::MODE_OFF: begin
                if (!en) begin
                    ctl_mode = ccdh_pkg::MODE_DISABLING;
                end else if (on_c) begin
                    ctl_mode  = ccdh_pkg::MODE_CONF_ON;
                    ctl_count = '0;
                end else if (repeat_due(it.now_ms)) begin
                    r.repeat_cmd = 1'b1;
                end
            end
            ccdh_pkg::MODE_CONF_ON: begin
                if (!en) begin
                    ctl_mode = ccdh_pkg::MODE_DISABLING;
                end else if (on_c) begin
                    bump_count();
                    if (ctl_count > model_cfg.debounce_limit) begin
                        ctl_mode         = ccdh_pkg::MODE_ON;
                        r.cool_start_cmd = 1'b1;
                        last_action      = it.now_ms;
                    end
                end else begin
                    ctl_count = '0;
                    ctl_mode  = ccdh_pkg::MODE_OFF;
                end
            end
            ccdh_pkg::MODE_ON: begin
                if (!en) begin
                    ctl_mode = ccdh_pkg::MODE_DISABLING;
                end else if (off_c) begin
                    ctl_mode  = ccdh_pkg::MODE_CONF_OFF;
                    ctl_count = '0;
                end else if (repeat_due(it.now_ms)) begin
                    r.repeat_cmd = 1'b1;
                end
            end
            ccdh_pkg::MODE_CONF_OFF: begin
                if (!en) begin
                    ctl_mode = ccdh_pkg::MODE_DISABLING;
                end else if (off_c) begin
                    bump_count();
                    if (ctl_count > model_cfg.debounce_limit) begin
                        ctl_mode        = ccdh_pkg::MODE_OFF;
                        r.cool_stop_cmd = 1'b1;
                        last_action     = it.now_ms;
                    end
                end else begin
                    ctl_count = '0;
                    ctl_mode  = ccdh_pkg::MODE_ON;
                end
            end
            ccdh_pkg::MODE_DISABLING: begin
                ctl_count = '0;
                ctl_mode  = ccdh_pkg::MODE_CONF_DIS;
            end
            ccdh_pkg::MODE_CONF_DIS: begin
                bump_count();
                if (!en) begin
                    if (ctl_count > model_cfg.debounce_limit) begin
                        r.cool_stop_cmd    = 1'b1;
                        r.power_toggle_cmd = 1'b1;
                        ctl_mode           = ccdh_pkg::MODE_DISABLED;
                    end
                end else begin
                    ctl_count = '0;
                    ctl_mode  = ccdh_pkg::MODE_OFF;
                end
            end
            ccdh_pkg::MODE_DISABLED: begin
                if (en) begin
                    ctl_mode  = ccdh_pkg::MODE_CONF_EN;
                    ctl_count = '0;
                end
            end
            ccdh_pkg::MODE_CONF_EN: begin
                bump_count();
                if (en) begin
                    if (ctl_count > model_cfg.debounce_limit) begin
                        r.power_toggle_cmd = 1'b1;
                        ctl_mode           = ccdh_pkg::MODE_OFF;
                    end
                end else begin
                    ctl_count = '0;
                    ctl_mode  = ccdh_pkg::MODE_DISABLED;
                end
            end
            ccdh_pkg::MODE_FAULT: begin
                r.fault_cmd = 1'b1;
                if (!it.sensor_error)
                    ctl_mode = ccdh_pkg::MODE_OFF;
            end
            default: begin
                ctl_mode = ccdh_pkg::MODE_OFF;
            end
        endcase
        r.mode_code = ctl_mode;
        return r;
    endfunction

    function automatic void set_reg(input logic [ccdh_pkg::CFG_IDX_W-1:0] idx,
                                    input logic [ccdh_pkg::MS_W-1:0] val);
        case (idx)
            ccdh_pkg::CFG_ON_INDEX:
                model_cfg.on_index_limit     = val[ccdh_pkg::VAL_W-1:0];
            ccdh_pkg::CFG_OFF_INDEX:
                model_cfg.off_index_limit    = val[ccdh_pkg::VAL_W-1:0];
            ccdh_pkg::CFG_HUMID_ON:
                model_cfg.humid_on_floor     = val[ccdh_pkg::VAL_W-1:0];
            ccdh_pkg::CFG_HUMID_OFF:
                model_cfg.humid_off_floor    = val[ccdh_pkg::VAL_W-1:0];
            ccdh_pkg::CFG_DEBOUNCE:
                model_cfg.debounce_limit     = val[ccdh_pkg::DEB_W-1:0];
            ccdh_pkg::CFG_REPEAT_INTV:
                model_cfg.repeat_interval_ms = val;
            default: ;
        endcase
    endfunction

    function automatic void queue_sample(input logic [ccdh_pkg::VAL_W-1:0] hi,
                                         input logic [ccdh_pkg::VAL_W-1:0] hu,
                                         input logic err, input logic en,
                                         input logic [ccdh_pkg::MS_W-1:0] ms);
        ccdh_pkg::item_t it;
        it.heat_index    = hi;
        it.humidity      = hu;
        it.sensor_error  = err;
        it.enable_switch = en;
        it.now_ms        = ms;
        pending_samples.push_back(it);
    endfunction

    // One run of samples sharing a tendency (hot, cold, in between, noise) and
    // mostly one switch level, from one to the debounce limit plus four samples long.
    function automatic int queue_run();
        int        len, pick, hi, hu, on_l, off_l, hon_l, hoff_l, r;
        logic      run_en, err, en;
        run_kind_t kind;
        on_l   = model_cfg.on_index_limit;
        off_l  = model_cfg.off_index_limit;
        hon_l  = model_cfg.humid_on_floor;
        hoff_l = model_cfg.humid_off_floor;
        pick   = $urandom_range(0, 9);
        kind   = pick < 4 ? RUN_HOT : pick < 7 ? RUN_COLD : pick < 8 ? RUN_MID : RUN_NOISE;
        len    = $urandom_range(1, model_cfg.debounce_limit + 4);
        run_en = ($urandom_range(0, 5) != 0);
        for (int k = 0; k < len; k++) begin
            case (kind)
                RUN_HOT: begin
                    hi = (on_l < VAL_MAX) ? $urandom_range(on_l + 1, VAL_MAX)
                                          : $urandom_range(0, VAL_MAX);
                    hu = (hon_l < VAL_MAX) ? $urandom_range(hon_l + 1, VAL_MAX)
                                           : $urandom_range(0, VAL_MAX);
                end
                RUN_COLD: begin
                    if ($urandom_range(0, 1) != 0) begin
                        hi = (off_l > 0) ? $urandom_range(0, off_l - 1) : 0;
                        hu = $urandom_range(0, VAL_MAX);
                    end else begin
                        hi = $urandom_range(0, VAL_MAX);
                        hu = (hoff_l > 0) ? $urandom_range(0, hoff_l - 1) : 0;
                    end
                end
                RUN_MID: begin
                    hi = $urandom_range(off_l, on_l);
                    hu = $urandom_range(hoff_l, VAL_MAX);
                end
                default: begin
                    hi = $urandom_range(0, VAL_MAX);
                    hu = $urandom_range(0, VAL_MAX);
                end
            endcase
            err = ($urandom_range(0, 39) == 0);
            en  = run_en ^ ($urandom_range(0, 24) == 0);
            // small steps mostly, some near the repeat interval, some wild jumps
            r = $urandom_range(0, 9);
            if (r < 6)
                stamp_ms = stamp_ms + $urandom_range(0, 1000);
            else if (r < 8)
                stamp_ms = stamp_ms + model_cfg.repeat_interval_ms - $urandom_range(0, 2);
            else if (r == 8)
                stamp_ms = $urandom;
            queue_sample(hi[ccdh_pkg::VAL_W-1:0], hu[ccdh_pkg::VAL_W-1:0], err, en,
                         stamp_ms);
        end
        return len;
    endfunction

    task automatic write_reg(input logic [ccdh_pkg::CFG_IDX_W-1:0] idx,
                             input logic [ccdh_pkg::MS_W-1:0] val);
        @(posedge aclk);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= val;
        set_reg(idx, val);
    endtask

    task automatic program_regs(input logic [ccdh_pkg::MS_W-1:0] on_l,
                                input logic [ccdh_pkg::MS_W-1:0] off_l,
                                input logic [ccdh_pkg::MS_W-1:0] hon,
                                input logic [ccdh_pkg::MS_W-1:0] hoff,
                                input logic [ccdh_pkg::MS_W-1:0] deb,
                                input logic [ccdh_pkg::MS_W-1:0] intv);
        write_reg(ccdh_pkg::CFG_ON_INDEX, on_l);
        write_reg(ccdh_pkg::CFG_OFF_INDEX, off_l);
        write_reg(ccdh_pkg::CFG_HUMID_ON, hon);
        write_reg(ccdh_pkg::CFG_HUMID_OFF, hoff);
        write_reg(ccdh_pkg::CFG_DEBOUNCE, deb);
        write_reg(ccdh_pkg::CFG_REPEAT_INTV, intv);
        @(posedge aclk);
        cfg_wr_en <= 1'b0;
    endtask

    // block is idle once every transfer has its result, plus pipeline slack
    task automatic drain();
        do @(negedge aclk);
        while (pending_samples.size() != 0 || s_tvalid || expected_results.size() != 0);
        repeat (4) @(negedge aclk);
    endtask

    task automatic run_phase(input int items, input int idle_pct);
        int n;
        n             = 0;
        src_idle_pct  = idle_pct;
        sink_idle_pct = idle_pct;
        while (n < items)
            n += queue_run();
        drain();
    endtask

    task automatic check_field(input string what, input int want, input int got);
        if (want != got) begin
            $display("%0t: %s mismatch, expected %0d actual %0d", $time, what, want, got);
            fail_count++;
        end
    endtask

    // sample driver
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_tvalid <= 1'b0;
            src_gap  <= 0;
        end else begin
            if (s_tvalid && s_tready)
                expected_results.push_back(cooler_step(offered));
            if (!s_tvalid || s_tready) begin
                if (src_gap != 0) begin
                    src_gap  <= src_gap - 1;
                    s_tvalid <= 1'b0;
                end else if (pending_samples.size() != 0) begin
                    offered  = pending_samples.pop_front();
                    s_tdata  <= {3'b000, offered.now_ms, offered.enable_switch,
                                 offered.humidity, offered.heat_index};
                    s_tuser  <= offered.sensor_error;
                    s_tvalid <= 1'b1;
                    if ($urandom_range(0, 99) < src_idle_pct)
                        src_gap <= $urandom_range(1, 6);
                end else begin
                    s_tvalid <= 1'b0;
                end
            end
        end
    end

    // result monitor and receiver stalls
    always @(posedge aclk) begin
        ccdh_pkg::result_t got, want;
        if (!aresetn) begin
            m_tready <= 1'b0;
        end else begin
            if (m_tvalid && m_tready) begin
                got = ccdh_pkg::result_t'(m_tdata[8:0]);
                results_seen++;
                if (expected_results.size() == 0) begin
                    $display("%0t: unexpected transfer, expected none actual %h",
                             $time, m_tdata);
                    fail_count++;
                end else begin
                    want = expected_results.pop_front();
                    check_field("mode_code", want.mode_code, got.mode_code);
                    check_field("cool_start_cmd", want.cool_start_cmd, got.cool_start_cmd);
                    check_field("cool_stop_cmd", want.cool_stop_cmd, got.cool_stop_cmd);
                    check_field("power_toggle_cmd", want.power_toggle_cmd,
                                got.power_toggle_cmd);
                    check_field("repeat_cmd", want.repeat_cmd, got.repeat_cmd);
                    check_field("fault_cmd", want.fault_cmd, got.fault_cmd);
                end
                // long hold-off so both stages fill and s_tready drops
                if (results_seen == 1000 || results_seen == 1800)
                    hold_left = 80;
            end
            if (hold_left != 0) begin
                hold_left--;
                m_tready <= 1'b0;
            end else if (sink_gap != 0) begin
                sink_gap--;
                m_tready <= 1'b0;
            end else if ($urandom_range(0, 99) < sink_idle_pct) begin
                sink_gap = $urandom_range(0, 5);
                m_tready <= 1'b0;
            end else begin
                m_tready <= 1'b1;
            end
        end
    end

    initial begin
        logic [ccdh_pkg::MS_W-1:0] intv;
        model_cfg.on_index_limit     = ccdh_pkg::RST_ON_INDEX;
        model_cfg.off_index_limit    = ccdh_pkg::RST_OFF_INDEX;
        model_cfg.humid_on_floor     = ccdh_pkg::RST_HUMID_ON;
        model_cfg.humid_off_floor    = ccdh_pkg::RST_HUMID_OFF;
        model_cfg.debounce_limit     = ccdh_pkg::RST_DEBOUNCE;
        model_cfg.repeat_interval_ms = ccdh_pkg::RST_REPEAT_INTV;
        ctl_mode    = ccdh_pkg::MODE_OFF;
        ctl_count   = '0;
        last_action = '0;

        repeat (9) @(posedge aclk);
        aresetn <= 1'b1;

        // directed walk with the default settings
        src_idle_pct  = 15;
        sink_idle_pct = 15;
        queue_sample(10'd0, 10'd0, 1'b0, 1'b1, 32'd0);
        queue_sample(10'd1000, 10'd0, 1'b0, 1'b1, 32'd600000);    // repeat exactly due
        queue_sample(10'd1023, 10'd1023, 1'b0, 1'b1, 32'd600001);
        for (int k = 0; k < 7; k++)                               // just above both limits
            queue_sample(10'd273, 10'd331, 1'b0, 1'b1, 32'd600002 + k);
        queue_sample(10'd267, 10'd1000, 1'b0, 1'b1, 32'd600100);  // index below off limit
        queue_sample(10'd268, 10'd300, 1'b0, 1'b1, 32'd600101);   // on the limits: back on
        queue_sample(10'd500, 10'd299, 1'b0, 1'b1, 32'd600102);   // humidity below floor
        queue_sample(10'd500, 10'd500, 1'b1, 1'b1, 32'd600103);   // fault
        queue_sample(10'd500, 10'd500, 1'b1, 1'b0, 32'd600104);
        queue_sample(10'd500, 10'd500, 1'b0, 1'b1, 32'd600105);   // fault clears to off
        queue_sample(10'd0, 10'd0, 1'b0, 1'b0, 32'hFFFF_FFFF);    // disabling
        queue_sample(10'd0, 10'd0, 1'b1, 1'b0, 32'hFFFF_FFFF);    // error ignored here
        queue_sample(10'd0, 10'd0, 1'b1, 1'b0, 32'd0);            // error in confirm disable
        queue_sample(10'd0, 10'd0, 1'b0, 1'b1, 32'd5);
        queue_sample(10'd0, 10'd0, 1'b0, 1'b1, 32'd5);            // elapsed wraps: repeat
        drain();

        run_phase(350, 20);

        // extremes: everything hot and cold at once, instant debounce, constant repeat
        program_regs(32'd0, 32'd1000, 32'd0, 32'd1000, 32'd0, 32'd0);
        run_phase(250, 0);

        program_regs(32'd1000, 32'd0, 32'd1000, 32'd0, 32'd15, 32'hFFFF_FFFF);
        run_phase(250, 30);

        // out-of-range indexes are ignored, wide values are masked
        write_reg(CFG_SPARE_6, $urandom);
        write_reg(CFG_SPARE_7, $urandom);
        program_regs(32'hABCD_E150, 32'hFFFF_F12C, 32'd400, 32'd350, 32'h1234_5673, 32'd1);
        run_phase(350, 25);

        for (int p = 0; p < 2; p++) begin
            case ($urandom_range(0, 2))
                0: intv = '0;
                1: intv = $urandom_range(1, 2000);
                default: intv = $urandom;
            endcase
            program_regs($urandom_range(0, 1000), $urandom_range(0, 1000),
                         $urandom_range(0, 1000), $urandom_range(0, 1000),
                         $urandom_range(0, 15), intv);
            run_phase(300, 10 + 15 * p);
        end

        // closing stretch without stalls
        program_regs(32'd280, 32'd260, 32'd400, 32'd380, 32'd1, 32'd500);
        run_phase(300, 0);

        repeat (8) @(posedge aclk);
        if (fail_count == 0 && expected_results.size() == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

    initial begin
        #2_000_000;
        $display("CHECK FAILED");
        $finish;
    end

endmodule
